>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the sliding window maximum RTL.
// Plain text macros only; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SWM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/swm_pkg.sv
// Package for the sliding window maximum unit: default sizes and the
// cell control struct. No dependencies.
package swm_pkg;

    localparam int MAX_WINDOW_DEF   = 64;
    localparam int SAMPLE_WIDTH_DEF = 32;
    localparam int CFG_WIDTH        = 7;

    // Broadcast from the top level to every cell of the candidate chain.
    typedef struct packed {
        logic step;   // an item is accepted this cycle
        logic clear;  // item starts a new sequence
        logic pop;    // front candidate leaves, chain shifts towards front
        logic full;   // chain full, drop front and put sample at back
    } swm_cell_ctrl_t;

endpackage

>>> hw/rtl/swm_in_if.sv
// Input item channel: valid/ready handshake carrying sample and first.
// Depends on swm_pkg for the default sample width.
interface swm_in_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                           first;

    modport source (output valid, output sample, output first, input ready);
    modport sink   (input valid, input sample, input first, output ready);
endinterface

>>> hw/rtl/swm_out_if.sv
// Result item channel: valid/ready handshake carrying window_max.
// Depends on swm_pkg for the default sample width.
interface swm_out_if #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] window_max;

    modport source (output valid, output window_max, input ready);
    modport sink   (input valid, input window_max, output ready);
endinterface

>>> hw/rtl/sliding_window_maximum_unit.sv
// Sliding window maximum unit: top level with chain of candidate cells,
// sample ring and result register. Depends on swm_pkg, swm_in_if, swm_out_if,
// swm_cell, swm_history and assert_macros.svh.

// The unit takes one signed sample per item and, once the current sequence
// holds window_size samples, returns the largest of the last window_size
// samples; shorter sequences give no result, and an item with first set
// starts a new sequence. window_size is clamped to 1..MAX_WINDOW and should
// be written only while the unit is idle. One item is accepted per clock
// cycle, sustained, as long as the result side takes its items: every cell
// of the candidate chain compares itself with the new sample in parallel and
// updates in the same cycle, and the ring read of the departing sample is
// issued ahead as a registered read, from the state the next item will see. A result
// appears in the output register the cycle after its item is accepted; while
// it waits the input is held off, and the next item is taken in the cycle
// the waiting result is taken. There is no clearing pass after reset: stale
// ring and cell contents are never read.
`include "assert_macros.svh"

module sliding_window_maximum_unit #(
    parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [swm_pkg::CFG_WIDTH-1:0]  cfg_wdata,
    swm_in_if.sink                         stream,
    swm_out_if.source                      result
);
    import swm_pkg::*;

    // ring index, window length and wrap arithmetic widths
    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW = $clog2(MAX_WINDOW + 1);
    localparam int RW = KW + 1;

    // clamp the register to 1..MAX_WINDOW
    function automatic logic [KW-1:0] eff_window(input logic [CFG_WIDTH-1:0] ws);
        logic [KW-1:0] k_clamp;
        if (ws == '0)
            k_clamp = KW'(1);
        else if (int'(ws) > MAX_WINDOW)
            k_clamp = KW'(MAX_WINDOW);
        else
            k_clamp = KW'(ws);
        return k_clamp;
    endfunction

    logic [CFG_WIDTH-1:0]           window_reg;
    logic [AW-1:0]                  hp_reg;
    logic [KW-1:0]                  ss_reg;
    logic                           out_vld_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_data_reg;

    logic                           acc;
    logic [KW-1:0]                  k;
    logic [KW-1:0]                  k_next;
    logic [KW-1:0]                  ss0;
    logic [KW-1:0]                  ss1;
    logic [KW-1:0]                  ss_next;
    logic                           depart;
    logic                           emit;
    logic [AW-1:0]                  hp0;
    logic [AW-1:0]                  hp_inc;
    logic [AW-1:0]                  hp_next;
    logic [RW-1:0]                  rd_h;
    logic [RW-1:0]                  rd_k;
    logic [AW-1:0]                  raddr;
    logic signed [SAMPLE_WIDTH-1:0] dep_data;
    swm_cell_ctrl_t                 ctrl;

    logic [MAX_WINDOW-1:0]          cell_valid;
    logic [MAX_WINDOW-1:0]          cell_kept;
    logic signed [SAMPLE_WIDTH-1:0] cell_data      [MAX_WINDOW];
    logic signed [SAMPLE_WIDTH-1:0] cell_data_next [MAX_WINDOW];

    assign acc          = stream.valid && stream.ready;
    assign stream.ready = !out_vld_reg || result.ready;

    // ---------------------------------------------------------------
    // sequence bookkeeping for the item at the input
    // ---------------------------------------------------------------
    always_comb
    begin
        k       = eff_window(window_reg);
        ss0     = stream.first ? '0 : ss_reg;
        ss1     = (ss0 > k) ? k : ss0;           // window shrunk mid-sequence
        depart  = (ss1 == k);                    // oldest sample leaves now
        ss_next = depart ? ss1 : KW'(ss1 + 1'b1);
        emit    = (ss_next == k);

        hp0     = stream.first ? '0 : hp_reg;
        hp_inc  = (hp0 == AW'(MAX_WINDOW - 1)) ? '0 : AW'(hp0 + 1'b1);
        hp_next = acc ? hp_inc : hp_reg;

        // prefetch the departing sample for whatever item comes next
        k_next  = eff_window(cfg_we ? cfg_wdata : window_reg);
        rd_h    = RW'(hp_next);
        rd_k    = RW'(k_next);
        if (rd_h >= rd_k)
            raddr = AW'(rd_h - rd_k);
        else
            raddr = AW'(rd_h + RW'(MAX_WINDOW) - rd_k);
    end

    // ---------------------------------------------------------------
    // chain control: pop the front if the departing sample matches it,
    // shift out the front on a full chain
    // ---------------------------------------------------------------
    always_comb
    begin
        ctrl.step  = acc;
        ctrl.clear = stream.first;
        ctrl.pop   = depart && cell_valid[0] && (dep_data == cell_data[0]);
        ctrl.full  = !ctrl.pop && !stream.first && cell_valid[MAX_WINDOW-1]
                     && !(stream.sample > cell_data[MAX_WINDOW-1]);
    end

    swm_history #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .DEPTH        (MAX_WINDOW)
    ) u_history (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (acc),
        .waddr (hp0),
        .wdata (stream.sample),
        .raddr (raddr),
        .rdata (dep_data)
    );

    // cell 0 is the queue front; the last cell takes the sample from its
    // right when the chain is full
    for (genvar i = 0; i < MAX_WINDOW; i++)
    begin : g_cell
        logic                           right_valid;
        logic signed [SAMPLE_WIDTH-1:0] right_data;
        logic                           left_kept;

        if (i == MAX_WINDOW - 1)
        begin : g_last
            assign right_valid = 1'b0;
            assign right_data  = stream.sample;
        end
        else
        begin : g_mid
            assign right_valid = cell_valid[i+1];
            assign right_data  = cell_data[i+1];
        end

        if (i == 0)
        begin : g_front
            assign left_kept = 1'b1;
        end
        else
        begin : g_rest
            assign left_kept = cell_kept[i-1];
        end

        swm_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .sample      (stream.sample),
            .right_valid (right_valid),
            .right_data  (right_data),
            .left_kept   (left_kept),
            .valid       (cell_valid[i]),
            .data        (cell_data[i]),
            .kept        (cell_kept[i]),
            .data_next   (cell_data_next[i])
        );
    end

    // ---------------------------------------------------------------
    // registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= CFG_WIDTH'(1);
            hp_reg      <= '0;
            ss_reg      <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                window_reg <= cfg_wdata;
            end
            if (acc)
            begin
                hp_reg <= hp_inc;
                ss_reg <= ss_next;
            end
            if (acc && emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // result is the new front of the chain
    always_ff @(posedge clk)
    begin
        if (acc && emit)
        begin
            out_data_reg <= cell_data_next[0];
        end
    end

    assign result.valid      = out_vld_reg;
    assign result.window_max = out_data_reg;

    // ---------------------------------------------------------------
    // assertions
    // ---------------------------------------------------------------
    `SWM_ASSERT_IMP(a_chain_prefix, clk, rst_n, 1'b1,
        (cell_valid & (cell_valid + 1'b1)) == '0, "candidate cells not a contiguous front run")
    `SWM_ASSERT_NXT(a_emit_loads, clk, rst_n, acc && emit,
        out_vld_reg && cell_valid[0], "emitting item left no result or empty chain")
    `SWM_ASSERT_IMP(a_result_has_front, clk, rst_n, out_vld_reg,
        cell_valid[0], "result pending while candidate chain is empty")

endmodule

>>> hw/rtl/swm_cell.sv
// One candidate cell of the monotonic queue chain.
// Depends on swm_pkg (swm_cell_ctrl_t).
module swm_cell #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  swm_pkg::swm_cell_ctrl_t        ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] sample,
    input  logic                           right_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] right_data,
    input  logic                           left_kept,
    output logic                           valid,
    output logic signed [SAMPLE_WIDTH-1:0] data,
    output logic                           kept,
    output logic signed [SAMPLE_WIDTH-1:0] data_next
);
    import swm_pkg::*;

    logic                           valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] data_reg;
    logic                           valid_next;
    logic                           cur_valid;
    logic signed [SAMPLE_WIDTH-1:0] cur_data;
    logic                           kill;
    logic                           append;

    always_comb
    begin
        // view after an optional front pop
        cur_valid = ctrl.clear ? 1'b0 : (ctrl.pop ? right_valid : valid_reg);
        cur_data  = ctrl.pop ? right_data : data_reg;
        kill      = cur_valid && (sample > cur_data);
        kept      = cur_valid && !kill;
        append    = !kept && left_kept;
        if (ctrl.full)
        begin
            valid_next = 1'b1;
            data_next  = right_data;
        end
        else
        begin
            valid_next = kept || append;
            data_next  = append ? sample : cur_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.step)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule

>>> hw/rtl/swm_history.sv
// Ring of recent samples: one write port, one registered read port with
// write-to-read bypass. Depends on swm_pkg for defaults.
module swm_history #(
    parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF,
    parameter int DEPTH        = swm_pkg::MAX_WINDOW_DEF,
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [AW-1:0]                  waddr,
    input  logic signed [SAMPLE_WIDTH-1:0] wdata,
    input  logic [AW-1:0]                  raddr,
    output logic signed [SAMPLE_WIDTH-1:0] rdata
);
    import swm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];
    logic signed [SAMPLE_WIDTH-1:0] rd_reg;
    logic signed [SAMPLE_WIDTH-1:0] byp_data_reg;
    logic                           byp_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_reg       <= mem[raddr];
        byp_data_reg <= wdata;
    end

    // read of the entry written in the same cycle returns the new sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_reg <= 1'b0;
        end
        else
        begin
            byp_reg <= we && (raddr == waddr);
        end
    end

    assign rdata = byp_reg ? byp_data_reg : rd_reg;

endmodule

>>> bench/tb_sliding_window_maximum_unit.sv
// Self-checking bench for sliding_window_maximum_unit: a directed table, then random phases
// of sequences, each result compared with an in-bench monotonic-queue predictor.
// Depends on swm_pkg, swm_in_if, swm_out_if and the unit RTL.
module tb_sliding_window_maximum_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_W         = swm_pkg::MAX_WINDOW_DEF;
    localparam int SMP_W         = swm_pkg::SAMPLE_WIDTH_DEF;
    localparam int CFG_W         = swm_pkg::CFG_WIDTH;
    localparam int CLK_PERIOD    = 10;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 1200;
    // result lands in the cycle after its item; settle cycles also cover items with no result
    localparam int SETTLE_CYCLES = 4;
    localparam int END_CYCLES    = 20;
    localparam int HOLD_CYCLES   = 120;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int KEEP_WINDOW   = -1;

    typedef logic [SMP_W-1:0] smp_t;

    localparam smp_t SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
    localparam smp_t SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};

    // How a table row is checked: by the predictor, no result, or a value typed in
    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_VALUE} exp_kind_e;

    // Sample shapes for the random sequences
    typedef enum logic [2:0] {
        FILL_RANDOM, FILL_TIES, FILL_RISING, FILL_FALLING, FILL_EXTREME
    } fill_mode_e;

    typedef struct packed {
        int        win;        // window to write first while idle, or KEEP_WINDOW
        smp_t      smp;
        logic      first_flag;
        exp_kind_e kind;
        smp_t      val;        // typed window maximum for EXP_VALUE rows
    } stim_row_t;

    localparam int DIRECTED_ROWS = 21;

    // Directed part. Window 1 from reset with no first flag, window 0 read as 1, a short
    // sequence, equal values kept in the queue, a restart part way, a window change
    // within a sequence, and the sample extremes.
    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        '{KEEP_WINDOW, SMP_MAX,      1'b0, EXP_VALUE, SMP_MAX},
        '{KEEP_WINDOW, SMP_MIN,      1'b0, EXP_VALUE, SMP_MIN},
        '{0,           32'hFFFFFFFF, 1'b1, EXP_VALUE, 32'hFFFFFFFF},
        '{3,           32'h00000005, 1'b1, EXP_NONE,  32'h0},
        '{KEEP_WINDOW, SMP_MIN,      1'b0, EXP_NONE,  32'h0},
        '{KEEP_WINDOW, 32'h00000005, 1'b0, EXP_VALUE, 32'h00000005},
        '{KEEP_WINDOW, SMP_MIN,      1'b0, EXP_VALUE, 32'h00000005},
        '{KEEP_WINDOW, SMP_MIN,      1'b0, EXP_VALUE, 32'h00000005},
        '{KEEP_WINDOW, SMP_MIN,      1'b0, EXP_VALUE, SMP_MIN},
        '{KEEP_WINDOW, SMP_MAX,      1'b1, EXP_NONE,  32'h0},
        '{KEEP_WINDOW, SMP_MAX,      1'b0, EXP_NONE,  32'h0},
        '{KEEP_WINDOW, 32'h80000001, 1'b0, EXP_VALUE, SMP_MAX},
        '{KEEP_WINDOW, 32'h00000000, 1'b1, EXP_NONE,  32'h0},
        '{2,           32'h12345678, 1'b0, EXP_MODEL, 32'h0},
        '{KEEP_WINDOW, 32'hEDCBA987, 1'b0, EXP_MODEL, 32'h0},
        '{KEEP_WINDOW, 32'h00000001, 1'b0, EXP_MODEL, 32'h0},
        '{1,           32'h55555555, 1'b0, EXP_MODEL, 32'h0},
        '{KEEP_WINDOW, 32'hAAAAAAAA, 1'b1, EXP_VALUE, 32'hAAAAAAAA},
        '{2,           32'h00000000, 1'b1, EXP_NONE,  32'h0},
        '{KEEP_WINDOW, 32'hFFFFFFFF, 1'b0, EXP_VALUE, 32'h00000000},
        '{KEEP_WINDOW, SMP_MIN,      1'b0, EXP_VALUE, 32'hFFFFFFFF}
    };

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    swm_in_if  #(.SAMPLE_WIDTH(SMP_W)) stream_if ();
    swm_out_if #(.SAMPLE_WIDTH(SMP_W)) result_if ();

    sliding_window_maximum_unit #(
        .MAX_WINDOW   (MAX_W),
        .SAMPLE_WIDTH (SMP_W)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .stream    (stream_if),
        .result    (result_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Predictor state: its own copy of the sample ring, the candidate queue and the window
    smp_t             hist_ring [MAX_W];
    smp_t             cand_ring [MAX_W];
    int unsigned      cand_head  = 0;
    int unsigned      cand_count = 0;
    int unsigned      hist_ptr   = 0;
    int unsigned      seq_seen   = 0;
    logic [CFG_W-1:0] window_reg = CFG_W'(1);

    // Expected window maxima, oldest first
    smp_t expected_max_q [$];

    int unsigned cycle_count    = 0;
    int unsigned error_count    = 0;
    int unsigned samples_sent   = 0;
    int unsigned maxima_checked = 0;
    int unsigned config_writes  = 0;
    int unsigned overflow_drops = 0;
    int unsigned rx_hold        = 0;   // receiver hold-off request, in cycles
    bit          tx_rush        = 1'b0; // sender offers back to back
    int unsigned tx_burst       = 0;
    smp_t        ramp_value     = '0;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d window maxima still pending",
                 cycle_count, expected_max_q.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic report_mismatch(input string what, input smp_t got, input smp_t want);
        $display("%0t: %s mismatch, got %0d, expected %0d", $time, what,
                 $signed(got), $signed(want));
        error_count++;
    endtask

    // Window maximum after one sample; returns 1 when the sequence is long enough for a
    // result. A full queue drops its front, which only a window change can bring about.
    function automatic bit predict_window_max(input smp_t s, input logic starts_seq,
                                              output smp_t wmax);
        int unsigned k;
        int unsigned idx;
        int unsigned back;
        k = window_reg;
        if (k < 1)
            k = 1;
        if (k > MAX_W)
            k = MAX_W;
        if (starts_seq)
        begin
            cand_head  = 0;
            cand_count = 0;
            hist_ptr   = 0;
            seq_seen   = 0;
        end
        if (seq_seen > k)
            seq_seen = k;
        // departing sample leaves only when it is the front value
        if (seq_seen == k)
        begin
            idx = (hist_ptr + MAX_W - k) % MAX_W;
            if (cand_count > 0 && hist_ring[idx] == cand_ring[cand_head])
            begin
                cand_head = (cand_head + 1) % MAX_W;
                cand_count--;
            end
        end
        // strictly smaller candidates at the back go; equal ones stay
        while (cand_count > 0)
        begin
            back = (cand_head + cand_count - 1) % MAX_W;
            if ($signed(s) > $signed(cand_ring[back]))
                cand_count--;
            else
                break;
        end
        if (cand_count >= MAX_W)
        begin
            cand_head = (cand_head + 1) % MAX_W;
            cand_count--;
            overflow_drops++;
        end
        cand_ring[(cand_head + cand_count) % MAX_W] = s;
        cand_count++;
        hist_ring[hist_ptr] = s;
        hist_ptr = (hist_ptr + 1) % MAX_W;
        if (seq_seen < k)
            seq_seen++;
        wmax = cand_ring[cand_head];
        return seq_seen >= k;
    endfunction

    // Idle cycles before an item: mostly a random gap, now and then a run of items with none
    function automatic int unsigned draw_gap(inout int unsigned burst_left);
        if (burst_left > 0)
        begin
            burst_left--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            burst_left = $urandom_range(20, 80);
            return 0;
        end
        return $urandom_range(0, 16);
    endfunction

    function automatic smp_t next_fill(input fill_mode_e mode);
        smp_t s;
        case (mode)
            FILL_TIES:    s = smp_t'(int'($urandom_range(0, 8)) - 4);
            FILL_RISING:
            begin
                ramp_value = ramp_value + $urandom_range(0, 3);
                s = ramp_value;
            end
            FILL_FALLING:
            begin
                ramp_value = ramp_value - $urandom_range(0, 3);
                s = ramp_value;
            end
            FILL_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       s = SMP_MIN;
                    1:       s = SMP_MAX;
                    2:       s = '0;
                    default: s = '1;
                endcase
            end
            default:      s = $urandom;
        endcase
        return s;
    endfunction

    // Offer one item, wait for its acceptance, then record what it should produce
    task automatic offer_sample(input smp_t s, input logic starts_seq,
                                input exp_kind_e kind, input smp_t typed_max);
        int unsigned gap;
        smp_t        wmax;
        bit          has_max;
        gap = tx_rush ? 0 : draw_gap(tx_burst);
        if (gap > 0)
        begin
            stream_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        stream_if.valid  <= 1'b1;
        stream_if.sample <= s;
        stream_if.first  <= starts_seq;
        do
            @(posedge clk);
        while (!stream_if.ready);
        has_max = predict_window_max(s, starts_seq, wmax);
        case (kind)
            EXP_MODEL:
            begin
                if (has_max)
                    expected_max_q.insert(expected_max_q.size(), wmax);
            end
            EXP_VALUE: expected_max_q.insert(expected_max_q.size(), typed_max);
            default:   ;
        endcase
        samples_sent++;
    endtask

    // Stop offering, let every expected maximum arrive, then let the unit settle
    task automatic drain_stream();
        stream_if.valid <= 1'b0;
        wait (expected_max_q.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_window(input int unsigned v);
        drain_stream();
        cfg_we    <= 1'b1;
        cfg_wdata <= v[CFG_W-1:0];
        @(posedge clk);
        cfg_we     <= 1'b0;
        window_reg = v[CFG_W-1:0];
        config_writes++;
    endtask

    // Result side: random stalls, the long hold-off on request, and the check itself
    initial
    begin
        int unsigned gap;
        int unsigned rx_burst;
        smp_t        want;
        rx_burst = 0;
        result_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (rx_hold > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (rx_hold) @(posedge clk);
                rx_hold = 0;
            end
            gap = draw_gap(rx_burst);
            if (gap > 0)
            begin
                result_if.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            result_if.ready <= 1'b1;
            do
                @(posedge clk);
            while (!result_if.valid);
            if (expected_max_q.size() == 0)
                report_mismatch("unexpected window_max", result_if.window_max, '0);
            else
            begin
                want = expected_max_q[0];
                expected_max_q.delete(0);
                if (result_if.window_max !== want)
                    report_mismatch("window_max", result_if.window_max, want);
                maxima_checked++;
            end
        end
    end

    // Sample side: reset, directed table, then random phases
    initial
    begin
        int          row;
        int          phase;
        int unsigned k_raw;
        int unsigned k_eff;
        int          n_seq;
        int          seq;
        int          len;
        int          i;
        bit          fresh;
        bit          forced;
        int          fixed_len;
        fill_mode_e  fixed_mode;
        fill_mode_e  mode;
        logic        starts_seq;

        stream_if.valid  <= 1'b0;
        stream_if.sample <= '0;
        stream_if.first  <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_wdata        <= '0;
        rst_n            <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            if (directed_rows[row].win != KEEP_WINDOW)
                write_window(directed_rows[row].win);
            offer_sample(directed_rows[row].smp, directed_rows[row].first_flag,
                         directed_rows[row].kind, directed_rows[row].val);
        end

        // Fixed opening phases: a falling run fills a 64-deep queue, a shrink to window 2
        // within that sequence forces front drops on a full queue, a back-to-back run
        // meets a long receiver hold-off, then the top register value (clamped to 64).
        // Later phases are random, with small windows favoured.
        phase      = 0;
        ramp_value = $urandom;
        while (samples_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            forced     = 1'b1;
            fresh      = 1'b1;
            n_seq      = 1;
            fixed_len  = 0;
            fixed_mode = FILL_RANDOM;
            case (phase)
                0:
                begin
                    k_raw      = 64;
                    fixed_len  = 80;
                    fixed_mode = FILL_FALLING;
                end
                1:
                begin
                    k_raw      = 2;
                    fresh      = 1'b0;
                    fixed_len  = 20;
                    fixed_mode = FILL_FALLING;
                end
                2:
                begin
                    k_raw     = 1;
                    fixed_len = 150;
                end
                3:
                begin
                    k_raw     = 127;
                    fixed_len = 70;
                end
                default:
                begin
                    forced = 1'b0;
                    case ($urandom_range(0, 9))
                        0, 1, 2, 3, 4, 5: k_raw = $urandom_range(1, 8);
                        6, 7:             k_raw = $urandom_range(9, 64);
                        8:
                        begin
                            case ($urandom_range(0, 2))
                                0:       k_raw = 0;
                                1:       k_raw = 63;
                                default: k_raw = 64;
                            endcase
                        end
                        default:          k_raw = $urandom_range(65, 127);
                    endcase
                    // now and then the new window applies to the running sequence
                    fresh = ($urandom_range(0, 3) != 0);
                end
            endcase
            k_eff = (k_raw < 1) ? 1 : ((k_raw > MAX_W) ? MAX_W : k_raw);
            if (!forced)
                n_seq = (k_eff > 16) ? 1 : $urandom_range(1, 4);

            write_window(k_raw);
            if (phase == 2)
            begin
                tx_rush = 1'b1;
                rx_hold = HOLD_CYCLES;
            end

            for (seq = 0; seq < n_seq; seq++)
            begin
                if (forced)
                begin
                    mode = fixed_mode;
                    len  = fixed_len;
                end
                else
                begin
                    mode       = fill_mode_e'($urandom_range(0, 4));
                    ramp_value = $urandom;
                    if (k_eff > 1 && $urandom_range(0, 5) == 0)
                        len = $urandom_range(1, k_eff - 1);   // too short for a result
                    else
                        len = k_eff - 1 + $urandom_range(1, 40);
                end
                for (i = 0; i < len; i++)
                begin
                    starts_seq = (i == 0) && (seq > 0 || fresh);
                    if (!forced && i > 0 && $urandom_range(0, 49) == 0)
                        starts_seq = 1'b1;
                    // occasional pause mid-sequence until the unit is empty
                    if (!tx_rush && $urandom_range(0, 39) == 0)
                        drain_stream();
                    offer_sample(next_fill(mode), starts_seq, EXP_MODEL, '0);
                end
            end
            tx_rush = 1'b0;
            phase++;
        end

        drain_stream();
        repeat (END_CYCLES) @(posedge clk);
        $display("Summary: %0d samples over %0d window settings, %0d window maxima checked",
                 samples_sent, config_writes, maxima_checked);
        $display("Summary: %0d full-queue drops, %0d-cycle receiver hold-off, %0d mismatches",
                 overflow_drops, HOLD_CYCLES, error_count);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
